### src/alternating_bit_sender_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the alternating bit sender
// Short forms for clocked concurrent checks used by the block checker.
// ---------------------------------------------------------------------------
`ifndef ALTERNATING_BIT_SENDER_MACROS_SVH
`define ALTERNATING_BIT_SENDER_MACROS_SVH

// check that is off while reset is asserted
`define ABS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds while reset is asserted
`define ABS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/abs_pkg.sv
// ---------------------------------------------------------------------------
// abs_pkg
// Types and constants shared by the alternating bit sender modules.
// ---------------------------------------------------------------------------
package abs_pkg;

	localparam int unsigned PAYLOAD_BYTES_DEF = 20;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd24;

	// request kinds
	localparam logic [1:0] KIND_MSG  = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	// acknowledgement codes
	localparam logic [1:0] ACK_SEQ0  = 2'd0;
	localparam logic [1:0] ACK_SEQ1  = 2'd1;
	localparam logic [1:0] ACK_NAK   = 2'd2;
	localparam logic [1:0] ACK_OTHER = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [1:0] ack_code;
	} item_t;

	typedef struct packed {
		logic        is_header;
		logic        seq_bit;
		logic [15:0] checksum;
		logic [7:0]  payload_byte;
		logic        is_last;
		logic        is_resend;
	} result_t;

	// send command from front to back
	typedef struct packed {
		logic        seq;
		logic [15:0] checksum;
		logic        resend;
	} cmd_t;

endpackage

### src/alternating_bit_sender.sv
// ---------------------------------------------------------------------------
// alternating_bit_sender
// Stop-and-wait sender: builds, checksums, sends and resends packets.
// ---------------------------------------------------------------------------
// Requests are message bytes, acknowledgements or timer ticks. PAYLOAD_BYTES
// message bytes collected while idle form a packet, which goes out as one
// header result and PAYLOAD_BYTES byte results; the sender then waits for
// the acknowledgement matching its sequence bit. A NAK, or timeout_ticks
// ticks with no acknowledgement, resends the packet with is_resend set.
// Bytes that arrive while waiting are dropped; other or corrupt acks and
// anything arriving while idle besides bytes are ignored. For a packet the
// transmit sequencer picks the command up, sends the header, then one
// result per byte, at one result per cycle when result_stall stays low.
// Up to two packet commands queue up behind the sequencer; item_stall
// rises when the queue is full, and a message byte arriving while idle is
// held off while any packet is still queued or going out, since new bytes
// would overwrite the packet in the byte store before it has been sent.
// cfg_ready is always high; timeout_ticks resets to 24 and a value of 0
// acts as 1.
// ---------------------------------------------------------------------------
module alternating_bit_sender import abs_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	// timeout_ticks write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);

	logic             push, q_full, q_not_empty, pop, busy;
	cmd_t             push_cmd, pop_cmd;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_data;

	assign cfg_ready = 1'b1;

	// front: decode, sequence bit, checksum, timer
	abs_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.back_active (busy || q_not_empty),
		.push        (push),
		.push_cmd    (push_cmd),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	// send commands waiting for the sequencer
	abs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (q_not_empty)
	);

	// back: byte store and transmit sequencer
	abs_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.q_not_empty  (q_not_empty),
		.q_cmd        (pop_cmd),
		.pop          (pop),
		.busy         (busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### src/abs_queue.sv
// ---------------------------------------------------------------------------
// abs_queue
// Two-entry command queue between the front and back of the sender.
// ---------------------------------------------------------------------------
module abs_queue import abs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### src/abs_front.sv
// ---------------------------------------------------------------------------
// abs_front
// Request decode, protocol state, checksum and retransmit timer.
// ---------------------------------------------------------------------------
module abs_front import abs_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	input  logic             cfg_valid,
	input  logic [15:0]      cfg_data,
	input  logic             q_full,
	input  logic             back_active,
	output logic             push,
	output cmd_t             push_cmd,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output logic [7:0]       wr_data
);

	logic             seq_q;
	logic             awaiting_q;
	logic [IDX_W-1:0] idx_q;
	logic [16:0]      sum_q;
	logic [15:0]      chk_q;
	logic [15:0]      ticks_q;
	logic [15:0]      timeout_q;
	logic [7:0]       hi_q;

	logic             accept;
	logic             is_msg, is_ack, is_tick;
	logic             last_byte, odd_byte;
	logic [16:0]      sum_base;
	logic [15:0]      add_w;
	logic [17:0]      sum_raw;
	logic [16:0]      sum_fold;
	logic [16:0]      sum_next;
	logic [15:0]      chk_next;
	logic             ack_match;
	logic             do_load, do_nak, do_expire;

	assign is_msg  = (item.kind == KIND_MSG);
	assign is_ack  = (item.kind == KIND_ACK);
	assign is_tick = (item.kind == KIND_TICK);

	// store must not change under a packet still being sent
	assign item_stall = q_full || (is_msg && !awaiting_q && back_active);
	assign accept     = item_valid && !item_stall;

	assign last_byte = (idx_q == IDX_W'(PAYLOAD_BYTES - 1));
	assign odd_byte  = idx_q[0];

	// folded one's complement sum, big-endian byte pairs
	always_comb begin
		sum_base = (idx_q == '0) ? {16'b0, seq_q} : sum_q;
		if (odd_byte)       add_w = {hi_q, item.data_byte};
		else if (last_byte) add_w = {item.data_byte, 8'h00};
		else                add_w = 16'h0000;
		sum_raw  = {1'b0, sum_base} + {2'b00, add_w};
		sum_fold = {15'b0, sum_raw[17:16]} + {1'b0, sum_raw[15:0]};
		sum_next = (odd_byte || last_byte) ? sum_fold : sum_base;
		chk_next = ~sum_next[15:0];
	end

	assign ack_match = (item.ack_code == (seq_q ? ACK_SEQ1 : ACK_SEQ0));

	assign do_load   = accept && is_msg && !awaiting_q && last_byte;
	assign do_nak    = accept && is_ack && awaiting_q && !ack_match
	                   && (item.ack_code == ACK_NAK);
	assign do_expire = accept && is_tick && awaiting_q && (ticks_q <= 16'd1);

	assign push            = do_load || do_nak || do_expire;
	assign push_cmd.seq    = seq_q;
	assign push_cmd.checksum = do_load ? chk_next : chk_q;
	assign push_cmd.resend = !do_load;

	assign wr_en   = accept && is_msg && !awaiting_q;
	assign wr_addr = idx_q;
	assign wr_data = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= 1'b0;
			awaiting_q <= 1'b0;
			idx_q      <= '0;
			sum_q      <= '0;
			chk_q      <= '0;
			ticks_q    <= '0;
			timeout_q  <= TIMEOUT_RESET;
		end else begin
			if (cfg_valid) timeout_q <= cfg_data;
			if (accept) begin
				if (is_msg && !awaiting_q) begin
					sum_q <= sum_next;
					if (last_byte) begin
						idx_q      <= '0;
						chk_q      <= chk_next;
						awaiting_q <= 1'b1;
						ticks_q    <= timeout_q;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end else if (is_ack && awaiting_q) begin
					if (ack_match) begin
						seq_q      <= ~seq_q;
						awaiting_q <= 1'b0;
						ticks_q    <= '0;
					end else if (do_nak) begin
						ticks_q <= timeout_q;
					end
				end else if (is_tick && awaiting_q) begin
					if (do_expire) ticks_q <= timeout_q;
					else ticks_q <= ticks_q - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) hi_q <= item.data_byte;
	end

endmodule

### src/abs_back.sv
// ---------------------------------------------------------------------------
// abs_back
// Packet store and transmit sequencer: header, then one result per byte.
// ---------------------------------------------------------------------------
module abs_back import abs_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             q_not_empty,
	input  cmd_t             q_cmd,
	output logic             pop,
	output logic             busy,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HDR  = 3'b010,
		ST_BYTE = 3'b100
	} back_state_t;

	back_state_t      state_q;
	cmd_t             cur_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       mem [PAYLOAD_BYTES];
	logic [7:0]       rd_data_q;
	result_t          out_q;
	logic             out_valid_q;

	logic             out_free;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             byte_last;

	assign out_free  = !out_valid_q || !result_stall;
	assign busy      = (state_q != ST_IDLE);
	assign pop       = (state_q == ST_IDLE) && q_not_empty;
	assign byte_last = (idx_q == IDX_W'(PAYLOAD_BYTES - 1));

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// read ahead one byte each time the output register is loaded, except for the last byte
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_HDR: begin
				rd_en = out_free;
			end
			ST_BYTE: begin
				rd_en   = out_free && !byte_last;
				rd_addr = idx_q + IDX_W'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (!result_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_not_empty) state_q <= ST_HDR;
				end
				ST_HDR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (byte_last) state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_cmd;
		if (state_q == ST_HDR && out_free) begin
			idx_q              <= '0;
			out_q.is_header    <= 1'b1;
			out_q.seq_bit      <= cur_q.seq;
			out_q.checksum     <= cur_q.checksum;
			out_q.payload_byte <= 8'h00;
			out_q.is_last      <= 1'b0;
			out_q.is_resend    <= cur_q.resend;
		end else if (state_q == ST_BYTE && out_free) begin
			idx_q              <= idx_q + IDX_W'(1);
			out_q.is_header    <= 1'b0;
			out_q.payload_byte <= rd_data_q;
			out_q.is_last      <= byte_last;
		end
	end

endmodule

### src/abs_checker.sv
// ---------------------------------------------------------------------------
// abs_checker
// Port-level checks on the sender's result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "alternating_bit_sender_macros.svh"

module abs_checker import abs_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// stalled result stays offered
	`ABS_ASSERT(a_valid_hold, result_valid && result_stall |=> result_valid, "result dropped")

	// stalled result does not change
	`ABS_ASSERT(a_data_hold, result_valid && result_stall |=> $stable(result), "result changed")

	// reset sampled low leaves no result offered
	`ABS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid, "result during reset")

	// within a packet the next result follows at once, same sequence bit
	`ABS_ASSERT(a_packet_burst, result_valid && !result_stall && !result.is_last |=> result_valid && !result.is_header && result.seq_bit == $past(result.seq_bit), "packet broken")

	// a packet ends before anything but a new header shows
	`ABS_ASSERT(a_packet_end, result_valid && !result_stall && result.is_last |=> !result_valid || result.is_header, "byte after last")

endmodule

bind alternating_bit_sender abs_checker u_abs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and scoreboard for the stop-and-wait sender. A clocked driver
// feeds requests from a pending queue, a predictor written in SV works out
// the frames each accepted request must produce, and a clocked monitor
// compares every accepted frame against the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_top;
	import abs_pkg::*;

	localparam int unsigned PAYLOAD_LEN   = PAYLOAD_BYTES_DEF;
	// request kind the sender must ignore
	localparam logic [1:0]  KIND_UNUSED   = 2'd3;
	// settle time used by wait_drained, sized from the payload length
	localparam int unsigned SETTLE_CYCLES = PAYLOAD_LEN + 2;
	localparam int unsigned LIMIT_CYCLES  = 400000;
	localparam int unsigned IDLE_PCT      = 34;
	localparam int unsigned REPORT_MAX    = 10;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data     = '0;

	// requests waiting to be driven, frames waiting to be seen
	item_t       requests_todo[$];
	result_t     frames_due[$];

	// while set, neither side inserts gaps
	bit          no_gaps        = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned frame_count    = 0;
	int unsigned cycle_count    = 0;

	// predictor state of the sender
	logic        seq_q       = 1'b0;
	bit          waiting_q   = 1'b0;
	int unsigned loaded_q    = 0;
	logic [7:0]  store_q [PAYLOAD_LEN];
	logic [16:0] sum_q       = '0;
	logic [15:0] chk_q       = '0;
	logic [15:0] ticks_q     = '0;
	logic [15:0] timeout_q   = TIMEOUT_RESET;

	always #2 clk = ~clk;

	alternating_bit_sender #(
		.PAYLOAD_BYTES(PAYLOAD_LEN)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// end-around carry: fold the upper half back into the low 16 bits
	function automatic logic [16:0] fold16(input logic [31:0] s);
		return {1'b0, s[31:16]} + {1'b0, s[15:0]};
	endfunction

	// header then one frame per stored byte; every send rearms the timer
	function automatic void queue_packet_frames(input logic resend);
		result_t f;
		f = '0;
		f.is_header = 1'b1;
		f.seq_bit   = seq_q;
		f.checksum  = chk_q;
		f.is_resend = resend;
		frames_due.push_back(f);
		for (int unsigned i = 0; i < PAYLOAD_LEN; i++) begin
			f.is_header    = 1'b0;
			f.payload_byte = store_q[i];
			f.is_last      = (i + 1 == PAYLOAD_LEN);
			frames_due.push_back(f);
		end
		ticks_q = timeout_q;
	endfunction

	function automatic void advance_sender(input item_t req);
		int unsigned idx;
		case (req.kind)
			KIND_MSG: begin
				// bytes arriving while a packet is outstanding are dropped
				if (!waiting_q) begin
					idx = (loaded_q >= PAYLOAD_LEN) ? 0 : loaded_q;
					// sum starts with the sequence word (seq bit, zero ack)
					if (idx == 0)
						sum_q = {16'b0, seq_q};
					store_q[idx] = req.data_byte;
					// big-endian pairs; an odd trailing byte gets a zero low half
					if (idx[0]) begin
						sum_q = fold16({15'b0, sum_q}
							+ {16'b0, store_q[idx - 1], req.data_byte});
					end else if (idx + 1 == PAYLOAD_LEN) begin
						sum_q = fold16({15'b0, sum_q} + {16'b0, req.data_byte, 8'h00});
					end
					idx++;
					if (idx < PAYLOAD_LEN) begin
						loaded_q = idx;
					end else begin
						loaded_q  = 0;
						chk_q     = ~sum_q[15:0];
						waiting_q = 1'b1;
						queue_packet_frames(1'b0);
					end
				end
			end
			KIND_ACK: begin
				// acks while idle are ignored; wrong-seq and corrupt acks leave
				// the timer alone
				if (waiting_q) begin
					if (req.ack_code == {1'b0, seq_q}) begin
						seq_q     = ~seq_q;
						waiting_q = 1'b0;
						ticks_q   = '0;
					end else if (req.ack_code == ACK_NAK) begin
						queue_packet_frames(1'b1);
					end
				end
			end
			KIND_TICK: begin
				// a zero timeout expires on the first tick, same as one
				if (waiting_q) begin
					if (ticks_q <= 16'd1)
						queue_packet_frames(1'b1);
					else
						ticks_q--;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			// request accepted at this edge: predict its frames
			if (item_valid && !item_stall)
				advance_sender(item);
			// load the next request only when the slot is free; a stalled
			// request stays put
			if (!item_valid || !item_stall) begin
				if (requests_todo.size() != 0
					&& (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					item_valid <= 1'b1;
					item       <= requests_todo.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Frame monitor
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("%0t frame %0d %s: expected %h, actual %h",
					$realtime, frame_count, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : mon
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (frames_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t frame %0d not predicted: %p",
							$realtime, frame_count, result);
				end else begin
					want = frames_due.pop_front();
					check_field("is_header",    want.is_header,    result.is_header);
					check_field("seq_bit",      want.seq_bit,      result.seq_bit);
					check_field("checksum",     want.checksum,     result.checksum);
					check_field("payload_byte", want.payload_byte, result.payload_byte);
					check_field("is_last",      want.is_last,      result.is_last);
					check_field("is_resend",    want.is_resend,    result.is_resend);
				end
				frame_count++;
			end
			result_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// hard stop for a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic item_t make_req(input logic [1:0] kind, input logic [7:0] data,
		input logic [1:0] ack);
		item_t r;
		r.kind      = kind;
		r.data_byte = data;
		r.ack_code  = ack;
		return r;
	endfunction

	function automatic void add_tick();
		requests_todo.push_back(make_req(KIND_TICK, 8'($urandom), 2'($urandom)));
	endfunction

	function automatic void add_ack(input logic [1:0] code);
		requests_todo.push_back(make_req(KIND_ACK, 8'($urandom), code));
	endfunction

	// one full message, extremes now and then
	function automatic void add_message();
		logic [7:0] b;
		for (int unsigned i = 0; i < PAYLOAD_LEN; i++) begin
			if ($urandom_range(9) == 0)
				b = $urandom_range(1) ? 8'hff : 8'h00;
			else
				b = 8'($urandom);
			requests_todo.push_back(make_req(KIND_MSG, b, 2'($urandom)));
		end
	endfunction

	// both acks in random order: exactly one matches the current seq bit,
	// the other is ignored by the sender
	function automatic void add_close();
		if ($urandom_range(1)) begin
			add_ack(ACK_SEQ0);
			add_ack(ACK_SEQ1);
		end else begin
			add_ack(ACK_SEQ1);
			add_ack(ACK_SEQ0);
		end
	endfunction

	// something that can happen while a packet is outstanding
	function automatic void add_disturbance();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			add_tick();
		else if (r < 65)
			add_ack(ACK_NAK);
		else if (r < 75)
			add_ack(ACK_OTHER);
		else if (r < 90)
			requests_todo.push_back(make_req(KIND_MSG, 8'($urandom), 2'($urandom)));
		else
			add_ack(2'($urandom));
	endfunction

	// mostly well-formed exchanges, some noise and unfinished ones
	function automatic void add_random_traffic(input int unsigned count);
		while (requests_todo.size() < count) begin
			if ($urandom_range(99) < 80) begin
				add_message();
				repeat ($urandom_range(6)) add_disturbance();
				if ($urandom_range(9) < 8)
					add_close();
			end else begin
				requests_todo.push_back(make_req(2'($urandom), 8'($urandom),
					2'($urandom)));
			end
		end
	endfunction

	// all requests taken, all frames seen, then let the last request retire
	task automatic wait_drained();
		do @(negedge clk);
		while (requests_todo.size() != 0 || item_valid || frames_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// called at a rising edge with the sender drained
	task automatic write_timeout(input logic [15:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		timeout_q = value;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ignored requests on an idle sender, one packet with
		// carry-heavy content, then each ack reaction and a dropped byte while waiting
		@(negedge clk);
		add_ack(ACK_SEQ0);
		add_tick();
		requests_todo.push_back(make_req(KIND_UNUSED, 8'hff, 2'b11));
		for (int unsigned i = 0; i < PAYLOAD_LEN; i++)
			requests_todo.push_back(make_req(KIND_MSG,
				(i == 0) ? 8'h00 : (i < 10) ? 8'hff : 8'($urandom), 2'b00));
		requests_todo.push_back(make_req(KIND_MSG, 8'h5a, 2'b11));
		add_ack(ACK_SEQ1);
		add_ack(ACK_OTHER);
		add_ack(ACK_NAK);
		add_ack(ACK_SEQ0);
		wait_drained();

		// shortest timeout: every tick resends; first half with no gaps
		write_timeout(16'd1);
		@(negedge clk);
		no_gaps = 1'b1;
		add_random_traffic(65);
		do @(negedge clk); while (requests_todo.size() > 32);
		no_gaps = 1'b0;
		wait_drained();

		// zero timeout must act like one tick
		write_timeout(16'd0);
		@(negedge clk);
		add_random_traffic(50);
		wait_drained();

		// longest timeout: ticks only count down, NAK still resends
		write_timeout(16'hffff);
		@(negedge clk);
		add_message();
		repeat (3) add_tick();
		add_ack(ACK_NAK);
		add_close();
		wait_drained();

		// short timeout so expiry and acks interleave
		write_timeout(16'd3);
		@(negedge clk);
		add_random_traffic(65);
		wait_drained();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
